### rtl/crcx_pkg.sv
package crcx_pkg;

   // CRC constants
   localparam logic [15:0] CrcAllOnes = 16'hFFFF;
   localparam logic [15:0] PolyReset  = 16'h8408;

   // default depth of the queue between front and back
   localparam int QueueDepth = 2;

   // one accepted byte word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } crcx_item_type;

   // head of the queue as offered to the back part
   typedef struct packed {
      logic          valid;
      crcx_item_type item;
   } crcx_head_type;

endpackage

### rtl/crcx_front.sv
module crcx_front import crcx_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_first_byte,
   input  logic          req_last_byte,
   output crcx_head_type head,
   input  logic          pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   crcx_item_type       slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push;
   crcx_item_type       item;

   // classify the incoming word into a queue entry
   always_comb begin
      item.data_byte  = req_data_byte;
      item.first_byte = req_first_byte;
      item.last_byte  = req_last_byte;
   end

   // stall only when every slot is taken
   assign req_stall = (count_ff == CntW'(Depth));
   assign push      = req_valid && !req_stall;

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the word in its slot
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   // offer the oldest word
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");
`endif

endmodule

### rtl/crcx_back.sv
module crcx_back import crcx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [15:0]   csr_write_data,
   input  crcx_head_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [15:0]   rsp_crc_value,
   output logic          rsp_end_of_message
);

   logic [15:0] poly_ff;
   logic [15:0] running_crc_ff, running_crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_crc_value_ff;
   logic        rsp_end_of_message_ff;
   logic [15:0] start_value;

   // fold one byte into the running value, eight shifts
   function automatic logic [15:0] fold_byte(input logic [15:0] value,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
      logic [15:0] v;
      v = value ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ poly;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

   // take the head whenever the output register is free or being drained
   assign pop = head.valid && (!rsp_valid_ff || !rsp_stall);

   assign start_value    = head.item.first_byte ? CrcAllOnes : running_crc_ff;
   assign running_crc_in = pop ? fold_byte(start_value, head.item.data_byte, poly_ff)
                               : running_crc_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold polynomial, running value and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff        <= PolyReset;
         running_crc_ff <= CrcAllOnes;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            poly_ff <= csr_write_data;
         end
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // load the result word on each pop
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_crc_value_ff      <= running_crc_in ^ CrcAllOnes;
         rsp_end_of_message_ff <= head.item.last_byte;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_crc_value      = rsp_crc_value_ff;
   assign rsp_end_of_message = rsp_end_of_message_ff;

`ifndef NO_ASSERTIONS
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped word not shown at output");
   a_crc_idle: assert property (@(posedge clock) disable iff (reset)
      !pop |=> $stable(running_crc_ff))
      else $error("running value moved without a word");
   a_result_matches: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_crc_value_ff == (running_crc_ff ^ CrcAllOnes)))
      else $error("result word differs from running value");
`endif

endmodule

### rtl/crc16_reflected_programmable_unit.sv
// Channel  Ports                                   Direction  Handshake
// req      req_data_byte, req_first_byte,          in         req_valid / req_stall
//          req_last_byte
// rsp      rsp_crc_value, rsp_end_of_message       out        rsp_valid / rsp_stall
// csr      csr_write_data (polynomial)             in         csr_write_enable
//
// One byte word per cycle sustained while rsp_stall is low; a word taken at req
// goes to rsp via a queue slot, then the output register fed by the eight-shift fold.
// Reset is synchronous and active high: polynomial 0x8408, running value all ones.
// req_stall rises only when all queue slots are full; rsp_stall holds the output
// register and, once the queue fills, backs up into req.
module crc16_reflected_programmable_unit import crcx_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_crc_value,
   output logic        rsp_end_of_message,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   crcx_head_type head;
   logic          pop;

   // accept and queue words
   crcx_front #(.Depth(Depth)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .head           (head),
      .pop            (pop)
   );

   // fold words and deliver results
   crcx_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_crc_value      (rsp_crc_value),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import crcx_pkg::*;

   localparam int QuietLimit = 5000;
   localparam int DrainCycles = 6;

   typedef struct packed {
      logic [15:0] crc_value;
      logic        end_of_message;
   } crc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_crc_value;
   logic        rsp_end_of_message;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   // words waiting to be sent and results waiting to arrive
   crcx_item_type  pending_words[$];
   crc_result_type expected_crcs[$];

   logic [15:0] poly_setting = PolyReset;
   logic [15:0] crc_state = CrcAllOnes;
   int          send_idle_pct = 32;
   int          recv_idle_pct = 75;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;

   crc16_reflected_programmable_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_crc_value      (rsp_crc_value),
      .rsp_end_of_message (rsp_end_of_message),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // fold one byte into the reflected CRC, least significant bit first
   function automatic logic [15:0] fold_crc_byte(input logic [15:0] value,
                                                 input logic [7:0]  data_val,
                                                 input logic [15:0] poly);
      logic [15:0] acc;
      logic        dropped;
      acc = value ^ {8'h00, data_val};
      for (int k = 0; k < 8; k++) begin
         dropped = acc[0];
         acc = acc >> 1;
         if (dropped) begin
            acc = acc ^ poly;
         end
      end
      return acc;
   endfunction

   function automatic logic [7:0] rand_data();
      case ($urandom_range(9))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic add_word(input logic [7:0] data_val, input logic first, input logic last);
      crcx_item_type w;
      w.data_byte = data_val;
      w.first_byte = first;
      w.last_byte = last;
      pending_words.push_back(w);
   endtask

   // mostly well-formed messages with random content, the rest stray flag patterns
   task automatic fill_random(input int n_words);
      int added;
      int len;
      added = 0;
      while (added < n_words) begin
         if ($urandom_range(99) < 85) begin
            len = ($urandom_range(9) == 0) ? int'($urandom_range(64, 13))
                                           : int'($urandom_range(12, 1));
            for (int k = 0; k < len; k++) begin
               add_word(rand_data(), k == 0, k == len - 1);
            end
            added += len;
         end else begin
            add_word(rand_data(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            added++;
         end
      end
   endtask

   // hold until every word is sent and every result is back, then let the pipe settle
   task automatic drain();
      do begin
         @(posedge clock);
      end while (pending_words.size() > 0 || req_valid || expected_crcs.size() > 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_polynomial(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      poly_setting = value;
   endtask

   // driver: predict the word taken at this edge, then offer the next one
   always @(posedge clock) begin
      crcx_item_type  w;
      crc_result_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_first_byte) begin
               crc_state = CrcAllOnes;
            end
            crc_state = fold_crc_byte(crc_state, req_data_byte, poly_setting);
            res.crc_value = crc_state ^ CrcAllOnes;
            res.end_of_message = req_last_byte;
            expected_crcs.push_back(res);
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= w.data_byte;
               req_first_byte <= w.first_byte;
               req_last_byte <= w.last_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      crc_result_type res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_crcs.size() == 0) begin
            $error("unexpected result word: crc_value %h end_of_message %b",
                   rsp_crc_value, rsp_end_of_message);
            mismatch_count++;
         end else begin
            res = expected_crcs.pop_front();
            if (rsp_crc_value !== res.crc_value) begin
               $error("crc_value: expected %h, actual %h", res.crc_value, rsp_crc_value);
               mismatch_count++;
            end
            if (rsp_end_of_message !== res.end_of_message) begin
               $error("end_of_message: expected %b, actual %b",
                      res.end_of_message, rsp_end_of_message);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: drop the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      logic [15:0] poly_list[6];
      string       check_str;
      poly_list = '{16'h0000, 16'hFFFF, 16'hA001, 16'($urandom), 16'h8408, 16'($urandom)};
      check_str = "123456789";

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // first message after reset relies on the reset value, no first flag
      add_word(8'h31, 1'b0, 1'b0);
      add_word(8'h32, 1'b0, 1'b0);
      add_word(8'h33, 1'b0, 1'b1);
      // standard check string with the reset polynomial
      for (int k = 0; k < 9; k++) begin
         add_word(check_str[k], k == 0, k == 8);
      end
      // continue straight on after a final byte without a first flag
      add_word(8'h00, 1'b0, 1'b1);
      // one-byte messages at the data extremes
      add_word(8'hFF, 1'b1, 1'b1);
      add_word(8'h00, 1'b1, 1'b1);
      add_word(8'h80, 1'b1, 1'b1);
      add_word(8'h01, 1'b1, 1'b1);
      // bare flags
      add_word(8'h55, 1'b0, 1'b0);
      add_word(8'hAA, 1'b1, 1'b0);
      add_word(8'h5A, 1'b0, 1'b1);
      drain();

      // random phases over several polynomials and idle patterns
      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 75;
         end else if (p < 4) begin
            send_idle_pct = 75;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_polynomial(poly_list[p]);
         fill_random(330);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
